// File: hdl/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int COLX_W   = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COPY_N   = (ROWS - 2) * COLUMNS;
  localparam int ROW_BASE = (ROWS - 2) * COLUMNS;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int ADDR_W    = 11;
  localparam int POS_W     = 11;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  localparam logic [ATTR_W-1:0] COLOR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } tcw_op_t;

  typedef struct packed {
    logic accept;
    logic put_step;
    logic home;
    logic rd_issue;
    logic copy_step;
    logic blank_step;
    logic clear_step;
    logic idx_clr;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    tcw_op_t op;
    logic    scroll;
    logic    copy_end;
    logic    row_end;
    logic    all_end;
    logic    out_free;
  } tcw_sts_t;

  function automatic logic [CELL_AW-1:0] cell_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return CELL_AW'(CELL_AW'(r) * CELL_AW'(COLUMNS) + CELL_AW'(c));
  endfunction

endpackage

// File: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/tcw_datapath.sv
// Cursor, cell store, sweep counter and result register of the console writer.
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_cmd_t             cmd,
  output tcw_sts_t             sts,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [CMD_W-1:0]     s_tuser,
  input  logic                 cfg_valid,
  input  logic [ATTR_W-1:0]    cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  tcw_op_t             item_op;
  logic [CHAR_W-1:0]   item_char;
  logic [ADDR_W-1:0]   item_addr;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [ATTR_W-1:0]   text_color;
  logic [CELL_AW-1:0]  idx;
  logic [POS_W-1:0]    out_pos;
  logic [CHAR_W-1:0]   out_char;
  logic [ATTR_W-1:0]   out_attr;

  logic [COL_W-1:0]    col_dec;
  logic [COLX_W-1:0]   colx;
  logic [ROW_W-1:0]    rowx;
  logic                put_we_c;
  logic                put_we_a;
  logic [CELL_AW-1:0]  put_addr;
  logic [CHAR_W-1:0]   put_char;
  logic                put_scroll;
  logic [ROW_W-1:0]    put_row;
  logic [COL_W-1:0]    put_col;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;
  logic                rd_ok;
  logic                copy_end;

  logic                we_c;
  logic                we_a;
  logic [CELL_AW-1:0]  waddr;
  logic [CHAR_W-1:0]   wd_c;
  logic [ATTR_W-1:0]   wd_a;
  logic                re;
  logic [CELL_AW-1:0]  raddr;
  logic [CHAR_W-1:0]   rd_c;
  logic [ATTR_W-1:0]   rd_a;

  assign rd_ok    = 32'(item_addr) < 32'(CELLS);
  assign copy_end = idx == CELL_AW'(COPY_N);

  always_comb begin
    col_dec  = cur_col - 1'b1;
    colx     = COLX_W'(cur_col);
    rowx     = cur_row;
    put_we_c = 1'b0;
    put_we_a = 1'b0;
    put_addr = cell_pos(cur_row, cur_col);
    put_char = item_char;
    case (item_char)
      KEY_BACKSPACE: begin
        if (cur_col != '0) begin
          colx     = COLX_W'(col_dec);
          put_we_c = 1'b1;
          put_addr = cell_pos(cur_row, col_dec);
          put_char = '0;
        end
      end
      KEY_NEWLINE: begin
        rowx = cur_row + 1'b1;
        colx = '0;
      end
      KEY_TAB: begin
        colx = COLX_W'(cur_col) + COLX_W'(TAB_STEP);
      end
      default: begin
        put_we_c = 1'b1;
        put_we_a = 1'b1;
        colx     = COLX_W'(cur_col) + 1'b1;
      end
    endcase
    if (colx >= COLX_W'(COLUMNS)) begin
      colx = '0;
      rowx = rowx + 1'b1;
    end
    put_scroll = rowx >= ROW_W'(ROWS - 1);
    put_row    = put_scroll ? rowx - 1'b1 : rowx;
    put_col    = COL_W'(colx);
  end

  always_comb begin
    col_next = cur_col;
    row_next = cur_row;
    if (cmd.home) begin
      col_next = '0;
      row_next = '0;
    end else if (cmd.put_step) begin
      col_next = put_col;
      row_next = put_row;
    end
  end

  always_comb begin
    we_c  = 1'b0;
    we_a  = 1'b0;
    waddr = put_addr;
    wd_c  = put_char;
    wd_a  = text_color;
    if (cmd.put_step) begin
      we_c = put_we_c;
      we_a = put_we_a;
    end else if (cmd.clear_step) begin
      we_c  = 1'b1;
      we_a  = 1'b1;
      waddr = idx;
      wd_c  = '0;
    end else if (cmd.blank_step) begin
      we_c  = 1'b1;
      we_a  = 1'b1;
      waddr = idx + CELL_AW'(ROW_BASE);
      wd_c  = '0;
    end else if (cmd.copy_step && idx != '0) begin
      we_c  = 1'b1;
      we_a  = 1'b1;
      waddr = idx - 1'b1;
      wd_c  = rd_c;
      wd_a  = rd_a;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = CELL_AW'(item_addr);
    if (cmd.rd_issue) begin
      re = rd_ok;
    end else if (cmd.copy_step && !copy_end) begin
      re    = 1'b1;
      raddr = idx + CELL_AW'(COLUMNS);
    end
  end

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr),
    .wdata (wd_c),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_c)
  );

  tcw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wd_a),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      text_color <= COLOR_RESET;
      idx        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      cur_col <= col_next;
      cur_row <= row_next;
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      if (cmd.accept || cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.copy_step || cmd.blank_step || cmd.clear_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op   <= tcw_op_t'(s_tuser);
      item_char <= s_tdata[CHAR_W-1:0];
      item_addr <= s_tdata[CHAR_W +: ADDR_W];
    end
    if (cmd.load_out) begin
      out_pos <= POS_W'(cell_pos(row_next, col_next));
      if (item_op == OP_READ && rd_ok) begin
        out_char <= rd_c;
        out_attr <= rd_a;
      end else begin
        out_char <= '0;
        out_attr <= '0;
      end
    end
  end

  assign m_tdata = {(M_TDATA_W - POS_W - CHAR_W - ATTR_W)'(0), out_attr, out_char, out_pos};

  assign sts.op       = item_op;
  assign sts.scroll   = put_scroll;
  assign sts.copy_end = copy_end;
  assign sts.row_end  = idx == CELL_AW'(COLUMNS - 1);
  assign sts.all_end  = idx == CELL_AW'(CELLS - 1);
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

// File: hdl/tcw_ctrl.sv
// Command sequencer of the console writer.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          OP_PUT: begin
            cmd.put_step = 1'b1;
            if (sts.scroll) begin
              state_next = ST_COPY;
            end else if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              state_next = ST_FINISH;
            end
          end
          OP_CLEAR: begin
            cmd.home   = 1'b1;
            state_next = ST_CLEAR;
          end
          OP_READ: begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_FINISH;
          end
          default: begin
            if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              state_next = ST_FINISH;
            end
          end
        endcase
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.row_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.all_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/text_console_writer_top.sv
// Top level of the text console writer: sequencer plus datapath.
//
//  Channel  Direction  Signals                     Contents (low bit up)
//  s        in         s_tvalid s_tready s_tdata   char_code[7:0] cell_address[18:8]
//                      s_tuser                     command[1:0]
//  m        out        m_tvalid m_tready m_tdata   cursor_pos[10:0] cell_char[18:11]
//                                                  cell_attr[26:19]
//  cfg      in         cfg_valid cfg_ready cfg_data text_color[7:0]
//
// Put: accept, then cursor update with the result loaded; unused commands load the result.
// Read: accept, cell store read, then the result loaded. A busy output delays the result.
// A put that scrolls then copies (ROWS-2)*COLUMNS cells up by one row, blanks row ROWS-2
// and loads the result; copy steps read and write the cell store at once.
// Clear homes the cursor, writes all COLUMNS*ROWS cells, then loads the result.
// Reset homes the cursor and sets text_color to 7; cell contents stay undefined.
// A stalled result holds in the output register; the next word is taken meanwhile.
`timescale 1ns / 1ps

module text_console_writer_top import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // char_code, cell_address
  input  logic [CMD_W-1:0]     s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // cursor_pos, cell_char, cell_attr
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: hdl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed or dropped");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[POS_W-1:0]) < 32'((ROWS - 1) * COLUMNS))
    else $error("cursor position reached the last row");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input word taken while the previous one is in work");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word shown right after reset");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);
